// File: hw/rtl/c3rb_pkg.sv
package c3rb_pkg;

    localparam int PIX_W        = 16;
    localparam int FRAC_W       = 14;
    localparam int WT_W         = 16;
    localparam int POS_W        = 11;
    localparam int SIZE_W       = 12;
    localparam int COEF_W       = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int TAPS         = 9;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam logic [COEF_W-1:0] COEF_TOP_RST = COEF_W'(0);
    localparam logic [COEF_W-1:0] COEF_MID_RST = COEF_W'(16384);
    localparam logic [COEF_W-1:0] COEF_BOT_RST = COEF_W'(0);
    localparam logic [SIZE_W-1:0] WIDTH_RST    = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RST   = SIZE_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP,
        CFG_COEF_MID,
        CFG_COEF_BOT,
        CFG_WIDTH,
        CFG_HEIGHT
    } cfg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } meta_t;

    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] pix;
        meta_t                      meta;
    } tap_req_t;

endpackage

// File: hw/rtl/c3rb_line_win.sv
module c3rb_line_win #(
    parameter int MAX_WIDTH  = c3rb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3rb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]           w_eff,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]          h_eff,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [c3rb_pkg::PIX_W-1:0]               s_pix,
    input  logic                                     s_start,
    output logic                                     tap_valid,
    input  logic                                     tap_ready,
    output c3rb_pkg::tap_req_t                       tap
);

    localparam int P  = c3rb_pkg::PIX_W;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [CW:0]   xs, xn;
    logic [RW:0]   ys, yn;
    logic [CW-1:0] x_cur;
    logic [RW-1:0] y_cur;
    logic [3:0]    mask_cur;

    logic          accept;
    logic          s1_valid_reg;
    logic [P-1:0]  s1_pix_reg;
    logic [CW-1:0] s1_x_reg;
    logic [RW-1:0] s1_y_reg;
    logic [3:0]    s1_mask_reg;
    logic          s1_x1_reg, s1_x2_reg, s1_y1_reg, s1_y2_reg;
    logic          s1_ready, s1_fire;

    logic [2*P-1:0] line_mem [MAX_WIDTH];
    logic [2*P-1:0] mem_rd_reg;
    logic [2*P-1:0] fwd_data_reg;
    logic           fwd_reg;
    logic [2*P-1:0] rd_word;
    logic [P-1:0]   up_pix, lo_pix;

    logic [2:0][2:0][P-1:0] win_reg;

    logic [3:0]    j_mask_reg;
    logic [CW-1:0] j_x_reg;
    logic [RW-1:0] j_y_reg;
    logic          j_x1_reg, j_x2_reg, j_y1_reg, j_y2_reg;
    logic [3:0]    sel_oh;
    logic          j_busy, j_issue, j_last, k_pass, k_col;
    logic [2:0][1:0] rs, cs;

    // position of the incoming pixel and of the one after it
    always_comb begin
        xs = {1'b0, col_reg};
        ys = {1'b0, row_reg};
        if (s_start) begin
            xs = '0;
            ys = '0;
        end
        if (32'(xs) >= 32'(w_eff)) begin
            xs = '0;
            ys = ys + 1'b1;
        end
        if (32'(ys) >= 32'(h_eff)) begin
            ys = '0;
        end
        x_cur = xs[CW-1:0];
        y_cur = ys[RW-1:0];
        xn = {1'b0, x_cur} + 1'b1;
        yn = {1'b0, y_cur} + 1'b1;
        col_next = xn[CW-1:0];
        row_next = y_cur;
        if (32'(xn) >= 32'(w_eff)) begin
            col_next = '0;
            row_next = (32'(yn) >= 32'(h_eff)) ? '0 : yn[RW-1:0];
        end
        mask_cur[0] = (y_cur != '0) && (x_cur != '0);
        mask_cur[1] = (y_cur != '0) && (32'(x_cur) == 32'(w_eff) - 32'd1);
        mask_cur[2] = (32'(y_cur) == 32'(h_eff) - 32'd1) && (x_cur != '0);
        mask_cur[3] = (32'(y_cur) == 32'(h_eff) - 32'd1)
                      && (32'(x_cur) == 32'(w_eff) - 32'd1);
    end

    assign s1_ready = !j_busy || (j_issue && j_last);
    assign s1_fire  = s1_valid_reg && s1_ready;
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_pix;
            s1_x_reg    <= x_cur;
            s1_y_reg    <= y_cur;
            s1_mask_reg <= mask_cur;
            s1_x1_reg   <= (x_cur != '0);
            s1_x2_reg   <= (32'(x_cur) >= 32'd2);
            s1_y1_reg   <= (y_cur != '0);
            s1_y2_reg   <= (32'(y_cur) >= 32'd2);
        end
    end

    // line buffer: upper row in the high half, lower row in the low half
    assign rd_word = fwd_reg ? fwd_data_reg : mem_rd_reg;
    assign up_pix  = rd_word[2*P-1:P];
    assign lo_pix  = rd_word[P-1:0];

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            line_mem[s1_x_reg] <= {lo_pix, s1_pix_reg};
        end
        if (accept) begin
            mem_rd_reg   <= line_mem[x_cur];
            fwd_reg      <= s1_fire && (s1_x_reg == x_cur);
            fwd_data_reg <= {lo_pix, s1_pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_fire) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_pix;
            win_reg[1][2] <= lo_pix;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // result sequencer, one window request per cycle while tap_ready is high
    assign j_busy  = |j_mask_reg;
    assign sel_oh  = j_mask_reg & (~j_mask_reg + 4'd1);
    assign j_last  = ((j_mask_reg & ~sel_oh) == 4'd0);
    assign j_issue = j_busy && tap_ready;
    assign k_pass  = sel_oh[2] | sel_oh[3];
    assign k_col   = sel_oh[1] | sel_oh[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_mask_reg <= '0;
        end else if (s1_fire) begin
            j_mask_reg <= s1_mask_reg;
        end else if (j_issue) begin
            j_mask_reg <= j_mask_reg & ~sel_oh;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            j_x_reg  <= s1_x_reg;
            j_y_reg  <= s1_y_reg;
            j_x1_reg <= s1_x1_reg;
            j_x2_reg <= s1_x2_reg;
            j_y1_reg <= s1_y1_reg;
            j_y2_reg <= s1_y2_reg;
        end
    end

    // replicate border rows and columns
    always_comb begin
        if (!k_pass) begin
            rs[0] = j_y2_reg ? 2'd0 : 2'd1;
            rs[1] = 2'd1;
            rs[2] = 2'd2;
        end else begin
            rs[0] = j_y1_reg ? 2'd1 : 2'd2;
            rs[1] = 2'd2;
            rs[2] = 2'd2;
        end
        if (!k_col) begin
            cs[0] = j_x2_reg ? 2'd0 : 2'd1;
            cs[1] = 2'd1;
            cs[2] = 2'd2;
        end else begin
            cs[0] = j_x1_reg ? 2'd1 : 2'd2;
            cs[1] = 2'd2;
            cs[2] = 2'd2;
        end
        for (int kr = 0; kr < 3; kr++) begin
            for (int kc = 0; kc < 3; kc++) begin
                tap.pix[kr*3+kc] = win_reg[rs[kr]][cs[kc]];
            end
        end
        tap.meta.col  = k_col  ? c3rb_pkg::POS_W'(j_x_reg)
                               : c3rb_pkg::POS_W'(j_x_reg - 1'b1);
        tap.meta.row  = k_pass ? c3rb_pkg::POS_W'(j_y_reg)
                               : c3rb_pkg::POS_W'(j_y_reg - 1'b1);
        tap.meta.last = j_last;
    end

    assign tap_valid = j_busy;

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_x_reg))
        else $error("stalled pixel lost its slot");

    a_last_single: assert property (@(posedge aclk) disable iff (!aresetn)
        j_issue && j_last |-> $countones(j_mask_reg) == 1)
        else $error("last request issued with more pending");

    a_job_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        j_busy && !j_issue && !s1_fire |=> $stable(j_mask_reg))
        else $error("pending requests changed while stalled");

    a_win_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire |=> win_reg[2][2] == $past(s1_pix_reg))
        else $error("window did not take the new pixel");
`endif

endmodule

// File: hw/rtl/c3rb_mac.sv
module c3rb_mac (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          tap_valid,
    output logic                                          tap_ready,
    input  c3rb_pkg::tap_req_t                            tap,
    input  logic [2:0][c3rb_pkg::COEF_W-1:0]              coef,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [c3rb_pkg::PIX_W-1:0]                    m_value,
    output logic [c3rb_pkg::POS_W-1:0]                    m_col,
    output logic [c3rb_pkg::POS_W-1:0]                    m_row,
    output logic                                          m_sat,
    output logic                                          m_last
);

    localparam int P  = c3rb_pkg::PIX_W;
    localparam int F  = c3rb_pkg::FRAC_W;
    localparam int WW = c3rb_pkg::WT_W;
    localparam int PW = P + WW;
    localparam int SW = PW + 2;
    localparam int TW = PW + 4;
    localparam logic signed [TW-1:0] ROUND = TW'(1) <<< (F - 1);
    localparam logic signed [TW-1:0] VMAX  = {{(TW-P+1){1'b0}}, {(P-1){1'b1}}};
    localparam logic signed [TW-1:0] VMIN  = {{(TW-P+1){1'b1}}, {(P-1){1'b0}}};

    logic signed [PW-1:0] prod_next [c3rb_pkg::TAPS];
    logic signed [PW-1:0] prod_reg  [c3rb_pkg::TAPS];
    logic signed [SW-1:0] rsum_reg  [3];
    c3rb_pkg::meta_t      p_meta_reg, r_meta_reg;
    logic                 p_valid_reg, r_valid_reg, o_valid_reg;
    logic                 p_ready, r_ready, o_ready;

    logic signed [TW-1:0] total, shifted;
    logic [P-1:0]         value_next;
    logic                 sat_next;

    logic [P-1:0]               o_value_reg;
    logic [c3rb_pkg::POS_W-1:0] o_col_reg, o_row_reg;
    logic                       o_sat_reg, o_last_reg;

    assign o_ready   = !o_valid_reg || m_ready;
    assign r_ready   = !r_valid_reg || o_ready;
    assign p_ready   = !p_valid_reg || r_ready;
    assign tap_ready = p_ready;

    for (genvar i = 0; i < c3rb_pkg::TAPS; i++) begin : g_mul
        assign prod_next[i] = $signed(tap.pix[i])
                            * $signed(coef[i/3][(i%3)*WW +: WW]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (p_ready) p_valid_reg <= tap_valid;
            if (r_ready) r_valid_reg <= p_valid_reg;
            if (o_ready) o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && tap_valid) begin
            for (int i = 0; i < c3rb_pkg::TAPS; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            p_meta_reg <= tap.meta;
        end
        if (r_ready && p_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                rsum_reg[r] <= SW'(prod_reg[3*r]) + SW'(prod_reg[3*r+1])
                             + SW'(prod_reg[3*r+2]);
            end
            r_meta_reg <= p_meta_reg;
        end
        if (o_ready && r_valid_reg) begin
            o_value_reg <= value_next;
            o_sat_reg   <= sat_next;
            o_col_reg   <= r_meta_reg.col;
            o_row_reg   <= r_meta_reg.row;
            o_last_reg  <= r_meta_reg.last;
        end
    end

    // round half up, drop fraction, clip
    always_comb begin
        total      = TW'(rsum_reg[0]) + TW'(rsum_reg[1]) + TW'(rsum_reg[2]) + ROUND;
        shifted    = total >>> F;
        sat_next   = 1'b0;
        value_next = shifted[P-1:0];
        if (shifted > VMAX) begin
            value_next = VMAX[P-1:0];
            sat_next   = 1'b1;
        end else if (shifted < VMIN) begin
            value_next = VMIN[P-1:0];
            sat_next   = 1'b1;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_value = o_value_reg;
    assign m_col   = o_col_reg;
    assign m_row   = o_row_reg;
    assign m_sat   = o_sat_reg;
    assign m_last  = o_last_reg;

endmodule

// File: hw/rtl/conv3x3_replicate_border_top.sv
// 3x3 convolution over a raster pixel stream, one signed 16-bit pixel per request on the
// s_ side, borders replicated from the nearest edge pixel. Each filtered pixel comes out
// tagged with its column and row once the source has moved one row and one column past it,
// so a pixel inside a row gives at most one result, the last pixel of a row up to two, and
// the last row gives its own results as well: up to four results for the final pixel.
// A source pixel is taken every clock while it gives at most one result and nothing stalls;
// a pixel with more results holds the input until its last one issues, as all results go
// one per cycle, when not stalled, through a single array of nine multipliers. A result
// passes the s1, window, job, product, row-sum and output registers. The two previous rows
// sit in one 32-bit wide line memory of MAX_WIDTH entries, read as a pixel is taken and
// written back from the s1 stage; it is not cleared after reset, so the block takes pixels
// right away. The user must write weights and image size through the cfg_ port only while
// no frame is in flight (not enforced); zero sizes count as one, oversize ones are clipped.
module conv3x3_replicate_border_top #(
    parameter int MAX_WIDTH  = c3rb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = c3rb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [c3rb_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [c3rb_pkg::COEF_W-1:0]       cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // pixel_value
    input  logic                              s_tuser,   // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // filtered_value, out_col, out_row
    output logic                              m_tuser,   // saturated
    output logic                              m_tlast
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [2:0][c3rb_pkg::COEF_W-1:0] coef_reg;
    logic [c3rb_pkg::SIZE_W-1:0]      width_reg, height_reg;
    logic [WW-1:0]                    w_eff;
    logic [HW-1:0]                    h_eff;

    logic                       tap_valid, tap_ready;
    c3rb_pkg::tap_req_t         tap;
    logic [c3rb_pkg::PIX_W-1:0] out_value;
    logic [c3rb_pkg::POS_W-1:0] out_col, out_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= c3rb_pkg::COEF_TOP_RST;
            coef_reg[1] <= c3rb_pkg::COEF_MID_RST;
            coef_reg[2] <= c3rb_pkg::COEF_BOT_RST;
            width_reg   <= c3rb_pkg::WIDTH_RST;
            height_reg  <= c3rb_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (c3rb_pkg::cfg_idx_t'(cfg_addr))
                c3rb_pkg::CFG_COEF_TOP: begin
                    coef_reg[0] <= cfg_wr_data;
                end
                c3rb_pkg::CFG_COEF_MID: begin
                    coef_reg[1] <= cfg_wr_data;
                end
                c3rb_pkg::CFG_COEF_BOT: begin
                    coef_reg[2] <= cfg_wr_data;
                end
                c3rb_pkg::CFG_WIDTH: begin
                    width_reg <= cfg_wr_data[c3rb_pkg::SIZE_W-1:0];
                end
                c3rb_pkg::CFG_HEIGHT: begin
                    height_reg <= cfg_wr_data[c3rb_pkg::SIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    c3rb_line_win #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line_win (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_pix     (s_tdata),
        .s_start   (s_tuser),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .tap       (tap)
    );

    c3rb_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .tap       (tap),
        .coef      (coef_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_value   (out_value),
        .m_col     (out_col),
        .m_row     (out_row),
        .m_sat     (m_tuser),
        .m_last    (m_tlast)
    );

    assign m_tdata = {2'b00, out_row, out_col, out_value};

endmodule
